// ----- hw/rtl/cia_pkg.sv -----
// cia_pkg: operation codes and port widths shared by the checked integer alu
// no dependencies
package cia_pkg;

    localparam int FUNC_W = 5;

    localparam logic [FUNC_W-1:0] OP_ADD = 5'd0;
    localparam logic [FUNC_W-1:0] OP_SUB = 5'd1;
    localparam logic [FUNC_W-1:0] OP_MUL = 5'd2;
    localparam logic [FUNC_W-1:0] OP_DIV = 5'd3;
    localparam logic [FUNC_W-1:0] OP_MOD = 5'd4;
    localparam logic [FUNC_W-1:0] OP_AND = 5'd5;
    localparam logic [FUNC_W-1:0] OP_OR  = 5'd6;
    localparam logic [FUNC_W-1:0] OP_XOR = 5'd7;
    localparam logic [FUNC_W-1:0] OP_SHL = 5'd8;
    localparam logic [FUNC_W-1:0] OP_SHR = 5'd9;
    localparam logic [FUNC_W-1:0] OP_EQ  = 5'd10;
    localparam logic [FUNC_W-1:0] OP_NE  = 5'd11;
    localparam logic [FUNC_W-1:0] OP_LT  = 5'd12;
    localparam logic [FUNC_W-1:0] OP_LE  = 5'd13;
    localparam logic [FUNC_W-1:0] OP_GT  = 5'd14;
    localparam logic [FUNC_W-1:0] OP_GE  = 5'd15;
    localparam logic [FUNC_W-1:0] OP_NEG = 5'd16;
    localparam logic [FUNC_W-1:0] OP_NOT = 5'd17;

    localparam int VALUE_W = 64;
    localparam int IN_TDATA_W = 136;

endpackage

// ----- hw/rtl/checked_integer_alu.sv -----
// checked_integer_alu: pipelined signed alu with overflow, divide and shift checks
// depends on cia_pkg for operation codes and port widths
//
// stages: stage 1, one restoring divider stage per quotient bit, output register
// throughput: one request per cycle unless the output stalls; the divider sets the
//   depth, the multiplier uses four half-width partial products
// reset: synchronous active-low i_rst_n clears every stage valid bit; payload
//   registers are not reset
module checked_integer_alu #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // func [4:0], left_value [68:5], right_value [132:69], zero pad above
    input  logic [cia_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // result_value [63:0]
    output logic [cia_pkg::VALUE_W-1:0]    m_axis_tdata,
    // result_valid [0]
    output logic [0:0]                     m_axis_tuser
);

    localparam int W  = DATA_WIDTH;
    localparam int SW = $clog2(W);
    localparam int L  = W / 2;
    localparam int U  = W - L;
    localparam int FW = cia_pkg::FUNC_W;
    localparam logic [W-1:0] MIN_MAG = {1'b1, {(W-1){1'b0}}};

    // one restoring divide iteration: returns {remainder, quotient shift}
    function automatic logic [2*W-1:0] div_step(input logic [W-1:0] rr,
                                                input logic [W-1:0] qq,
                                                input logic [W-1:0] dd);
        logic [W:0]   trial;
        logic [W-1:0] nr;
        logic [W-1:0] nq;
        trial = {rr, qq[W-1]} - {1'b0, dd};
        if (!trial[W]) begin
            nr = trial[W-1:0];
            nq = {qq[W-2:0], 1'b1};
        end else begin
            nr = {rr[W-2:0], qq[W-1]};
            nq = {qq[W-2:0], 1'b0};
        end
        return {nr, nq};
    endfunction

    // stall control: whole pipe moves when the output register is free or taken
    logic w_adv;
    assign w_adv         = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // input field unpack, low DATA_WIDTH bits of each value field taken as signed
    logic [FW-1:0]       w_in_f;
    logic signed [W-1:0] w_in_a;
    logic signed [W-1:0] w_in_b;
    assign w_in_f = s_axis_tdata[FW-1:0];
    assign w_in_a = signed'(s_axis_tdata[FW +: W]);
    assign w_in_b = signed'(s_axis_tdata[FW+cia_pkg::VALUE_W +: W]);

    // stage 1: operands and magnitudes
    logic                r_v1;
    logic [FW-1:0]       r_f1;
    logic signed [W-1:0] r_a1;
    logic signed [W-1:0] r_b1;
    logic [W-1:0]        r_ma1;
    logic [W-1:0]        r_mb1;

    // simple operations, evaluated between stage 1 and the pipe
    logic [W-1:0]        w_bu;
    logic                w_sh_ok;
    logic [SW-1:0]       w_sh_amt;
    logic signed [W-1:0] w_sum;
    logic signed [W-1:0] w_dif;
    logic signed [W-1:0] n_sr;
    logic                n_sok;

    assign w_bu     = r_b1;
    assign w_sh_ok  = w_bu < W'(W);
    assign w_sh_amt = w_bu[SW-1:0];
    assign w_sum    = r_a1 + r_b1;
    assign w_dif    = r_a1 - r_b1;

    always_comb begin
        n_sr  = '0;
        n_sok = 1'b1;
        unique case (r_f1)
            cia_pkg::OP_ADD: begin
                n_sr  = w_sum;
                n_sok = !(r_a1[W-1] == r_b1[W-1] && w_sum[W-1] != r_a1[W-1]);
            end
            cia_pkg::OP_SUB: begin
                n_sr  = w_dif;
                n_sok = !(r_a1[W-1] != r_b1[W-1] && w_dif[W-1] != r_a1[W-1]);
            end
            cia_pkg::OP_MUL, cia_pkg::OP_DIV, cia_pkg::OP_MOD: begin
                n_sr  = '0;
                n_sok = 1'b1;
            end
            cia_pkg::OP_AND: n_sr = r_a1 & r_b1;
            cia_pkg::OP_OR:  n_sr = r_a1 | r_b1;
            cia_pkg::OP_XOR: n_sr = r_a1 ^ r_b1;
            cia_pkg::OP_SHL: begin
                n_sr  = r_a1 << w_sh_amt;
                n_sok = w_sh_ok;
            end
            cia_pkg::OP_SHR: begin
                n_sr  = r_a1 >>> w_sh_amt;
                n_sok = w_sh_ok;
            end
            cia_pkg::OP_EQ: n_sr = W'(r_a1 == r_b1);
            cia_pkg::OP_NE: n_sr = W'(r_a1 != r_b1);
            cia_pkg::OP_LT: n_sr = W'(r_a1 < r_b1);
            cia_pkg::OP_LE: n_sr = W'(r_a1 <= r_b1);
            cia_pkg::OP_GT: n_sr = W'(r_a1 > r_b1);
            cia_pkg::OP_GE: n_sr = W'(r_a1 >= r_b1);
            cia_pkg::OP_NEG: begin
                n_sr  = -r_a1;
                n_sok = r_a1 != signed'(MIN_MAG);
            end
            cia_pkg::OP_NOT: n_sr = ~r_a1;
            default: begin
                n_sr  = '0;
                n_sok = 1'b0;
            end
        endcase
    end

    // main pipe: one divider iteration per stage, side data carried alongside
    logic [W-1:0]              r_v;
    logic [FW-1:0]             r_f   [W];
    logic [W-1:0]              r_sa;
    logic [W-1:0]              r_qn;
    logic [W-1:0]              r_bz;
    logic [W-1:0]              r_sok;
    logic signed [W-1:0]       r_sr  [W];
    logic [W-1:0]              r_dr  [W];
    logic [W-1:0]              r_dq  [W];
    logic [W-1:0]              r_dd  [W];
    logic [2*W-1:0]            r_prod[1:W-1];

    // multiplier partial products, in step with pipe stage 0
    logic [2*L-1:0]            r_p0;
    logic [L+U-1:0]            r_p1;
    logic [L+U-1:0]            r_p2;
    logic [2*U-1:0]            r_p3;

    logic [2*W-1:0]            w_prod0;
    assign w_prod0 = (2*W)'(r_p0)
                   + (((2*W)'(r_p1) + (2*W)'(r_p2)) << L)
                   + ((2*W)'(r_p3) << (2*L));

    logic [2*W-1:0] w_ds0;
    assign w_ds0 = div_step('0, r_ma1, r_mb1);

    logic [2*W-1:0] w_ds [1:W-1];
    for (genvar g = 1; g < W; g++) begin : g_div
        assign w_ds[g] = div_step(r_dr[g-1], r_dq[g-1], r_dd[g-1]);
    end

    // output stage: magnitude to signed with range check, then select
    logic [W-1:0]        w_mag;
    logic                w_neg;
    logic                w_pre_ok;
    logic                w_fm_ok;
    logic signed [W-1:0] w_res;
    logic                n_ook;
    logic [cia_pkg::VALUE_W-1:0] n_oval;

    always_comb begin
        w_mag    = '0;
        w_neg    = 1'b0;
        w_pre_ok = 1'b1;
        unique case (r_f[W-1])
            cia_pkg::OP_MUL: begin
                w_mag    = r_prod[W-1][W-1:0];
                w_neg    = r_qn[W-1];
                w_pre_ok = r_prod[W-1][2*W-1:W] == '0;
            end
            cia_pkg::OP_DIV: begin
                w_mag    = r_dq[W-1];
                w_neg    = r_qn[W-1];
                w_pre_ok = !r_bz[W-1];
            end
            cia_pkg::OP_MOD: begin
                w_mag    = r_dr[W-1];
                w_neg    = r_sa[W-1];
                w_pre_ok = !r_bz[W-1];
            end
            default: begin
                w_mag    = '0;
                w_neg    = 1'b0;
                w_pre_ok = 1'b1;
            end
        endcase
        w_fm_ok = w_neg ? (w_mag <= MIN_MAG) : (w_mag < MIN_MAG);
        if (r_f[W-1] == cia_pkg::OP_MUL || r_f[W-1] == cia_pkg::OP_DIV
                || r_f[W-1] == cia_pkg::OP_MOD) begin
            w_res = w_neg ? -signed'(w_mag) : signed'(w_mag);
            n_ook = w_pre_ok && w_fm_ok;
        end else begin
            w_res = r_sr[W-1];
            n_ook = r_sok[W-1];
        end
        n_oval = n_ook ? cia_pkg::VALUE_W'(w_res) : '0;
    end

    logic                        r_ov;
    logic                        r_ook;
    logic [cia_pkg::VALUE_W-1:0] r_oval;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= s_axis_tvalid;
            r_v  <= {r_v[W-2:0], r_v1};
            r_ov <= r_v[W-1];
        end
    end

    // payload, held whole while stalled
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1  <= w_in_f;
            r_a1  <= w_in_a;
            r_b1  <= w_in_b;
            r_ma1 <= w_in_a[W-1] ? -w_in_a : w_in_a;
            r_mb1 <= w_in_b[W-1] ? -w_in_b : w_in_b;

            r_p0 <= r_ma1[L-1:0] * r_mb1[L-1:0];
            r_p1 <= r_ma1[L-1:0] * r_mb1[W-1:L];
            r_p2 <= r_ma1[W-1:L] * r_mb1[L-1:0];
            r_p3 <= r_ma1[W-1:L] * r_mb1[W-1:L];

            r_f[0]   <= r_f1;
            r_sa[0]  <= r_a1[W-1];
            r_qn[0]  <= r_a1[W-1] ^ r_b1[W-1];
            r_bz[0]  <= r_b1 == '0;
            r_sr[0]  <= n_sr;
            r_sok[0] <= n_sok;
            r_dr[0]  <= w_ds0[2*W-1:W];
            r_dq[0]  <= w_ds0[W-1:0];
            r_dd[0]  <= r_mb1;
            r_prod[1] <= w_prod0;

            for (int k = 1; k < W; k++) begin
                r_f[k]   <= r_f[k-1];
                r_sa[k]  <= r_sa[k-1];
                r_qn[k]  <= r_qn[k-1];
                r_bz[k]  <= r_bz[k-1];
                r_sr[k]  <= r_sr[k-1];
                r_sok[k] <= r_sok[k-1];
                r_dr[k]  <= w_ds[k][2*W-1:W];
                r_dq[k]  <= w_ds[k][W-1:0];
                r_dd[k]  <= r_dd[k-1];
            end
            for (int k = 2; k < W; k++) begin
                r_prod[k] <= r_prod[k-1];
            end

            r_ook  <= n_ook;
            r_oval <= n_oval;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_oval;
    assign m_axis_tuser  = r_ook;

    // a flagged result always carries a zero value
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("flagged result with non-zero value");

    // input side ready follows the output register only
    a_ready_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready not tied to output register state");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid straight after reset");

    // a stalled result keeps its value and flag
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

// ----- tb/checked_integer_alu_test.sv -----
// checked_integer_alu_test: self-checking stream testbench for the checked integer alu
// depends on cia_pkg and checked_integer_alu; holds its own result predictor
`timescale 1ns / 1ps

// scoreboard: predicts one result per accepted request, checks results in order
class alu_scoreboard;
    typedef struct packed {
        logic [63:0] value;
        logic        ok;
    } t_alu_result;

    t_alu_result pending_results[$];
    int          error_count;

    function automatic logic [127:0] mag_product(logic [63:0] a, logic [63:0] b);
        return {64'd0, a} * {64'd0, b};
    endfunction

    function automatic logic [63:0] abs_of(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    // signed value from magnitude and sign, ok cleared when out of range
    function automatic void signed_from_mag(logic [63:0] mag, logic neg,
                                            output logic [63:0] r, output logic ok);
        ok = neg ? (mag <= 64'h8000_0000_0000_0000) : (mag <= 64'h7fff_ffff_ffff_ffff);
        r  = neg ? -mag : mag;
    endfunction

    function automatic t_alu_result compute_result(logic [4:0] op, logic signed [63:0] a,
                                                   logic signed [63:0] b);
        t_alu_result res;
        logic [63:0] r;
        logic [63:0] t;
        logic [127:0] p;
        logic ok;
        r  = '0;
        ok = 1'b1;
        case (op)
            cia_pkg::OP_ADD: begin
                t  = a + b;
                ok = !(a[63] == b[63] && t[63] != a[63]);
                r  = t;
            end
            cia_pkg::OP_SUB: begin
                t  = a - b;
                ok = !(a[63] != b[63] && t[63] != a[63]);
                r  = t;
            end
            cia_pkg::OP_MUL: begin
                p = mag_product(abs_of(a), abs_of(b));
                signed_from_mag(p[63:0], a[63] != b[63], r, ok);
                if (p[127:64] != 0) ok = 1'b0;
            end
            cia_pkg::OP_DIV: begin
                if (b == 0) ok = 1'b0;
                else signed_from_mag(abs_of(a) / abs_of(b), a[63] != b[63], r, ok);
            end
            cia_pkg::OP_MOD: begin
                if (b == 0) ok = 1'b0;
                else signed_from_mag(abs_of(a) % abs_of(b), a[63], r, ok);
            end
            cia_pkg::OP_AND: r = a & b;
            cia_pkg::OP_OR:  r = a | b;
            cia_pkg::OP_XOR: r = a ^ b;
            cia_pkg::OP_SHL: begin
                if ($unsigned(b) >= 64) ok = 1'b0;
                else r = a << b[5:0];
            end
            cia_pkg::OP_SHR: begin
                if ($unsigned(b) >= 64) ok = 1'b0;
                else r = a >>> b[5:0];
            end
            cia_pkg::OP_EQ: r = {63'd0, a == b};
            cia_pkg::OP_NE: r = {63'd0, a != b};
            cia_pkg::OP_LT: r = {63'd0, a < b};
            cia_pkg::OP_LE: r = {63'd0, a <= b};
            cia_pkg::OP_GT: r = {63'd0, a > b};
            cia_pkg::OP_GE: r = {63'd0, a >= b};
            cia_pkg::OP_NEG: begin
                ok = a != 64'h8000_0000_0000_0000;
                r  = -a;
            end
            cia_pkg::OP_NOT: r = ~a;
            default: ok = 1'b0;
        endcase
        res.value = ok ? r : 64'd0;
        res.ok    = ok;
        return res;
    endfunction

    function void note_request(logic [4:0] op, logic [63:0] a, logic [63:0] b);
        pending_results.insert(pending_results.size(), compute_result(op, a, b));
    endfunction

    task report_mismatch(string what);
        $display("mismatch: %s", what);
        error_count++;
    endtask

    task check_result(logic [63:0] value, logic ok);
        t_alu_result want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h/%b", value, ok));
            return;
        end
        want = pending_results.pop_front();
        if (value !== want.value)
            report_mismatch($sformatf("value %h, wanted %h", value, want.value));
        if (ok !== want.ok)
            report_mismatch($sformatf("valid flag %b, wanted %b", ok, want.ok));
    endtask
endclass

module checked_integer_alu_test;

    localparam int LATENCY     = 66;
    localparam int CYCLE_LIMIT = 200000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    // func [4:0], left_value [68:5], right_value [132:69], zero pad above
    logic [cia_pkg::IN_TDATA_W-1:0] s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    // result_value [63:0]
    logic [cia_pkg::VALUE_W-1:0]    m_axis_tdata;
    // result_valid [0]
    logic [0:0]                     m_axis_tuser;

    alu_scoreboard results_board;
    int            sender_idle_pct;
    int            receiver_idle_pct;
    int            hold_off_cycles;
    int            cycle_count;

    checked_integer_alu dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver: random stall, or a long hold-off while hold_off_cycles counts down
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready   <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // accepted results go straight to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            results_board.check_result(m_axis_tdata, m_axis_tuser[0]);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("checked_integer_alu test failed");
            $finish;
        end
    end

    // offer one request, hold it until accepted, then note it
    task automatic send_request(logic [4:0] op, logic [63:0] a, logic [63:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'd0, b, a, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        results_board.note_request(op, a, b);
    endtask

    // operands biased toward edges: extremes, small values, shift amounts, random
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return 64'(signed'($urandom_range(6)) - 3);
            3: return 64'($urandom_range(70));
            4: return {{32{1'b0}}, $urandom()} ^ {64{$urandom_range(1) == 1}};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    localparam logic [4:0] OP_UNKNOWN_TOP = 5'd31;

    task automatic run_random(int count);
        logic [4:0] op;
        for (int n = 0; n < count; n++) begin
            // mostly defined codes, some unknown ones
            op = ($urandom_range(9) == 0)
                ? 5'($urandom_range(OP_UNKNOWN_TOP, cia_pkg::OP_NOT + 1))
                : 5'($urandom_range(cia_pkg::OP_NOT));
            send_request(op, pick_operand(), pick_operand());
        end
    endtask

    task automatic drain();
        while (results_board.pending_results.size() != 0) @(posedge i_clk);
    endtask

    localparam logic [63:0] MIN_V = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_V = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] NEG1  = '1;

    initial begin
        results_board     = new();
        i_rst_n           = 1'b0;
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = '0;
        m_axis_tready     = 1'b0;
        sender_idle_pct   = 22;
        receiver_idle_pct = 67;
        hold_off_cycles   = 0;
        cycle_count       = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each operation and the named corner cases
        send_request(cia_pkg::OP_ADD, MAX_V, 64'd1);            // add overflow
        send_request(cia_pkg::OP_ADD, MIN_V, NEG1);             // add underflow
        send_request(cia_pkg::OP_SUB, MIN_V, 64'd1);            // sub overflow
        send_request(cia_pkg::OP_SUB, 64'd5, 64'd9);
        // exact overflow to minimum neg
        send_request(cia_pkg::OP_MUL, 64'h1_0000_0000, 64'h8000_0000);
        // minimum, valid
        send_request(cia_pkg::OP_MUL, 64'hffff_ffff_0000_0000, 64'h8000_0000);
        send_request(cia_pkg::OP_MUL, MIN_V, NEG1);
        send_request(cia_pkg::OP_DIV, 64'd7, 64'd0);            // divide by zero
        send_request(cia_pkg::OP_DIV, MIN_V, NEG1);             // minimum by -1
        send_request(cia_pkg::OP_DIV, -64'd7, 64'd2);           // truncation toward zero
        send_request(cia_pkg::OP_MOD, MIN_V, NEG1);             // gives zero, valid
        send_request(cia_pkg::OP_MOD, -64'd7, 64'd2);
        send_request(cia_pkg::OP_MOD, 64'd7, 64'd0);
        send_request(cia_pkg::OP_AND, MIN_V, NEG1);
        send_request(cia_pkg::OP_OR, MAX_V, MIN_V);
        send_request(cia_pkg::OP_XOR, NEG1, MAX_V);
        send_request(cia_pkg::OP_SHL, NEG1, 64'd63);            // wrapping shift
        send_request(cia_pkg::OP_SHL, 64'd1, 64'd64);           // bad shift amount
        send_request(cia_pkg::OP_SHR, MIN_V, 64'd63);
        send_request(cia_pkg::OP_SHR, MIN_V, NEG1);             // negative amount
        send_request(cia_pkg::OP_EQ, MIN_V, MIN_V);
        send_request(cia_pkg::OP_NE, MIN_V, MAX_V);
        send_request(cia_pkg::OP_LT, MIN_V, MAX_V);
        send_request(cia_pkg::OP_NEG, MIN_V, 64'd3);            // negate overflow
        send_request(cia_pkg::OP_NOT, MAX_V, NEG1);
        send_request(OP_UNKNOWN_TOP, MAX_V, MAX_V);             // unknown code

        // long hold-off so the pipeline fills and stalls its input
        hold_off_cycles = 300;
        run_random(150);

        // swap idling ratios, then run flat out
        sender_idle_pct   = 67;
        receiver_idle_pct = 22;
        run_random(250);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random(300);
        s_axis_tvalid <= 1'b0;

        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (results_board.error_count == 0 && results_board.pending_results.size() == 0) begin
            $display("checked_integer_alu test passed");
        end else begin
            $display("checked_integer_alu test failed");
        end
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/cia_pkg.sv
hw/rtl/checked_integer_alu.sv
tb/checked_integer_alu_test.sv
